// ----- hw/rtl/nec_ir_frame_decoder_macros.svh -----
// Assertion macros used by the checker file.
// Every assertion is clocked on clk_i and held off while rst_ni is low.
`ifndef NEC_IR_FRAME_DECODER_MACROS_SVH
`define NEC_IR_FRAME_DECODER_MACROS_SVH

// Same-cycle or overlapping property.
`define NECIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define NECIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/necir_pkg.sv -----
package necir_pkg;

  localparam int unsigned DurW          = 15;
  localparam int unsigned CountW        = 6;
  localparam int unsigned CountMax      = (1 << CountW) - 1;
  localparam int unsigned FullSymbols   = 34;
  localparam int unsigned RepeatSymbols = 2;
  localparam int unsigned HalfBits      = 16;
  localparam int unsigned PayloadBits   = 2 * HalfBits;
  localparam int unsigned BitIdxW       = $clog2(PayloadBits);
  localparam int unsigned RegIdxW       = 3;
  localparam int unsigned InDataW       = 32;
  localparam int unsigned OutDataW      = 32;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] RegMargin      = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegLeadMark    = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegLeadSpace   = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegRepeatMark  = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegRepeatSpace = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegBitMark     = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] RegZeroSpace   = RegIdxW'(6);
  localparam logic [RegIdxW-1:0] RegOneSpace    = RegIdxW'(7);

  typedef logic [DurW-1:0] dur_t;

  localparam dur_t MarginRst      = DurW'(200);
  localparam dur_t LeadMarkRst    = DurW'(9000);
  localparam dur_t LeadSpaceRst   = DurW'(4500);
  localparam dur_t RepeatMarkRst  = DurW'(9000);
  localparam dur_t RepeatSpaceRst = DurW'(2250);
  localparam dur_t BitMarkRst     = DurW'(560);
  localparam dur_t ZeroSpaceRst   = DurW'(560);
  localparam dur_t OneSpaceRst    = DurW'(1690);

  typedef struct packed {
    dur_t margin;
    dur_t lead_mark;
    dur_t lead_space;
    dur_t repeat_mark;
    dur_t repeat_space;
    dur_t bit_mark;
    dur_t zero_space;
    dur_t one_space;
  } cfg_t;

  typedef struct packed {
    logic lead;
    logic rpt;
    logic one;
    logic zero;
  } match_t;

  // Strict window test: spec - margin < d < spec + margin, no wrap.
  function automatic logic near_spec(dur_t d, dur_t spec, dur_t margin);
    logic [DurW:0] dx;
    logic [DurW:0] sx;
    logic [DurW:0] mx;
    dx = {1'b0, d};
    sx = {1'b0, spec};
    mx = {1'b0, margin};
    return (dx < (sx + mx)) && ((dx + mx) > sx);
  endfunction

endpackage

// ----- hw/rtl/nec_ir_frame_decoder.sv -----
// Path: a closing symbol's beat passes the input register, then the result register.
// Throughput: one symbol beat per cycle; the input register advances whenever the
//   result register is empty or being drained in the same cycle.
// Reset (rst_ni low, asynchronous): registers take their default timings, frame
//   state, held address/command and both valid flags clear; no clearing pass.
module nec_ir_frame_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [necir_pkg::RegIdxW-1:0]      cfg_idx_i,
  input  logic [necir_pkg::DurW-1:0]         cfg_wdata_i,
  // symbol stream in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [necir_pkg::InDataW-1:0]      s_axis_tdata,  // mark_ticks, space_ticks, pad
  input  logic                               s_axis_tlast,  // last_symbol
  // frame result stream out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [necir_pkg::OutDataW-1:0]     m_axis_tdata,  // address, command
  output logic                               m_axis_tuser   // is_repeat
);

  necir_pkg::cfg_t   cfg_q, cfg_d;
  logic              in_valid_q, in_valid_d;
  necir_pkg::dur_t   mark_q, space_q;
  logic              last_q;
  logic              s_fire, proc;
  logic              out_valid;
  necir_pkg::match_t match;
  logic [necir_pkg::HalfBits-1:0] addr, cmd;
  logic              rpt;

  // Configuration registers: user must write only while the block is idle (unchecked).
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        necir_pkg::RegMargin:      cfg_d.margin       = cfg_wdata_i;
        necir_pkg::RegLeadMark:    cfg_d.lead_mark    = cfg_wdata_i;
        necir_pkg::RegLeadSpace:   cfg_d.lead_space   = cfg_wdata_i;
        necir_pkg::RegRepeatMark:  cfg_d.repeat_mark  = cfg_wdata_i;
        necir_pkg::RegRepeatSpace: cfg_d.repeat_space = cfg_wdata_i;
        necir_pkg::RegBitMark:     cfg_d.bit_mark     = cfg_wdata_i;
        necir_pkg::RegZeroSpace:   cfg_d.zero_space   = cfg_wdata_i;
        necir_pkg::RegOneSpace:    cfg_d.one_space    = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin       <= necir_pkg::MarginRst;
      cfg_q.lead_mark    <= necir_pkg::LeadMarkRst;
      cfg_q.lead_space   <= necir_pkg::LeadSpaceRst;
      cfg_q.repeat_mark  <= necir_pkg::RepeatMarkRst;
      cfg_q.repeat_space <= necir_pkg::RepeatSpaceRst;
      cfg_q.bit_mark     <= necir_pkg::BitMarkRst;
      cfg_q.zero_space   <= necir_pkg::ZeroSpaceRst;
      cfg_q.one_space    <= necir_pkg::OneSpaceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register: hold a symbol beat until the decode stage takes it.
  // The decode stage advances when the result register can take a beat.
  assign proc          = in_valid_q && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_fire || (in_valid_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mark_q  <= s_axis_tdata[necir_pkg::DurW-1:0];
      space_q <= s_axis_tdata[2*necir_pkg::DurW-1:necir_pkg::DurW];
      last_q  <= s_axis_tlast;
    end
  end

  // Window compares against every spec pair
  necir_match u_match (
    .mark_i  (mark_q),
    .space_i (space_q),
    .cfg_i   (cfg_q),
    .match_o (match)
  );

  // Frame tracking, held values and the result register
  necir_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .last_i      (last_q),
    .match_i     (match),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_valid),
    .addr_o      (addr),
    .cmd_o       (cmd),
    .rpt_o       (rpt)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {cmd, addr};
  assign m_axis_tuser  = rpt;

endmodule

// ----- hw/rtl/necir_match.sv -----
module necir_match (
  input  necir_pkg::dur_t   mark_i,
  input  necir_pkg::dur_t   space_i,
  input  necir_pkg::cfg_t   cfg_i,
  output necir_pkg::match_t match_o
);

  logic bit_mark_ok;

  assign bit_mark_ok = necir_pkg::near_spec(mark_i, cfg_i.bit_mark, cfg_i.margin);

  assign match_o.lead = necir_pkg::near_spec(mark_i, cfg_i.lead_mark, cfg_i.margin)
                     && necir_pkg::near_spec(space_i, cfg_i.lead_space, cfg_i.margin);
  assign match_o.rpt  = necir_pkg::near_spec(mark_i, cfg_i.repeat_mark, cfg_i.margin)
                     && necir_pkg::near_spec(space_i, cfg_i.repeat_space, cfg_i.margin);
  assign match_o.one  = bit_mark_ok
                     && necir_pkg::near_spec(space_i, cfg_i.one_space, cfg_i.margin);
  assign match_o.zero = bit_mark_ok
                     && necir_pkg::near_spec(space_i, cfg_i.zero_space, cfg_i.margin);

endmodule

// ----- hw/rtl/necir_frame.sv -----
module necir_frame (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          proc_i,
  input  logic                          last_i,
  input  necir_pkg::match_t             match_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [necir_pkg::HalfBits-1:0] addr_o,
  output logic [necir_pkg::HalfBits-1:0] cmd_o,
  output logic                          rpt_o
);

  logic [necir_pkg::CountW-1:0]      count_q, count_d, count_inc;
  logic                              leader_q, leader_d;
  logic                              repeat_q, repeat_d;
  logic                              err_q, err_d;
  logic [necir_pkg::PayloadBits-1:0] shift_q, shift_d;
  logic [necir_pkg::HalfBits-1:0]    held_addr_q, held_addr_d;
  logic [necir_pkg::HalfBits-1:0]    held_cmd_q, held_cmd_d;
  logic                              out_valid_q, out_valid_d;
  logic [necir_pkg::HalfBits-1:0]    addr_q, addr_d;
  logic [necir_pkg::HalfBits-1:0]    cmd_q, cmd_d;
  logic                              rpt_q, rpt_d;
  logic [necir_pkg::BitIdxW-1:0]     bit_idx;
  logic                              is_first, is_payload;
  logic                              full_ok, rpt_ok;

  assign is_first   = (count_q == '0);
  assign is_payload = !is_first
                   && (count_q <= necir_pkg::CountW'(necir_pkg::PayloadBits));
  assign bit_idx    = necir_pkg::BitIdxW'(count_q - necir_pkg::CountW'(1));
  assign count_inc  = (count_q == necir_pkg::CountW'(necir_pkg::CountMax))
                    ? count_q : count_q + necir_pkg::CountW'(1);

  always_comb begin
    leader_d = leader_q;
    repeat_d = repeat_q;
    err_d    = err_q;
    shift_d  = shift_q;
    if (is_first) begin
      leader_d = match_i.lead;
      repeat_d = match_i.rpt;
    end else if (is_payload) begin
      // a symbol that fits both windows decodes as one
      if (match_i.one || match_i.zero) begin
        shift_d[bit_idx] = match_i.one;
      end else begin
        err_d = 1'b1;
      end
    end
  end

  assign full_ok = last_i && (count_inc == necir_pkg::CountW'(necir_pkg::FullSymbols))
                && leader_d && !err_d;
  assign rpt_ok  = last_i && (count_inc == necir_pkg::CountW'(necir_pkg::RepeatSymbols))
                && repeat_d;

  always_comb begin
    count_d     = count_q;
    held_addr_d = held_addr_q;
    held_cmd_d  = held_cmd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    rpt_d       = rpt_q;
    if (proc_i) begin
      count_d = count_inc;
      if (full_ok) begin
        held_addr_d = shift_d[necir_pkg::HalfBits-1:0];
        held_cmd_d  = shift_d[necir_pkg::PayloadBits-1:necir_pkg::HalfBits];
        addr_d      = shift_d[necir_pkg::HalfBits-1:0];
        cmd_d       = shift_d[necir_pkg::PayloadBits-1:necir_pkg::HalfBits];
        rpt_d       = 1'b0;
        out_valid_d = 1'b1;
      end else if (rpt_ok) begin
        addr_d      = held_addr_q;
        cmd_d       = held_cmd_q;
        rpt_d       = 1'b1;
        out_valid_d = 1'b1;
      end
      if (last_i) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      leader_q    <= 1'b0;
      repeat_q    <= 1'b0;
      err_q       <= 1'b0;
      shift_q     <= '0;
      held_addr_q <= '0;
      held_cmd_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      held_addr_q <= held_addr_d;
      held_cmd_q  <= held_cmd_d;
      out_valid_q <= out_valid_d;
      if (proc_i) begin
        // clear per-frame state after the closing symbol
        leader_q <= last_i ? 1'b0 : leader_d;
        repeat_q <= last_i ? 1'b0 : repeat_d;
        err_q    <= last_i ? 1'b0 : err_d;
        shift_q  <= last_i ? '0 : shift_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cmd_q  <= cmd_d;
    rpt_q  <= rpt_d;
  end

  assign out_valid_o = out_valid_q;
  assign addr_o      = addr_q;
  assign cmd_o       = cmd_q;
  assign rpt_o       = rpt_q;

endmodule

// ----- hw/rtl/necir_checker.sv -----
`include "nec_ir_frame_decoder_macros.svh"

module necir_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [necir_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  logic [necir_pkg::OutDataW-1:0] last_full_q;
  logic                           s_beat, m_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  // Track the payload of the most recent full-frame result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_full_q <= '0;
    end else if (m_beat && !m_axis_tuser) begin
      last_full_q <= m_axis_tdata;
    end
  end

  `NECIR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
  `NECIR_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty result register")
  `NECIR_ASSERT(a_repeat_payload, (m_beat && m_axis_tuser) |-> (m_axis_tdata == last_full_q), "repeat beat differs from last full frame")
  `NECIR_ASSERT(a_result_cause, $rose(m_axis_tvalid) |-> $past(s_beat, 2), "result beat without a symbol beat two cycles earlier")

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (.*);

// ----- tb/nec_ir_frame_decoder_test.sv -----
module nec_ir_frame_decoder_test;
  import necir_pkg::*;

  localparam int DurMax        = (1 << DurW) - 1;
  localparam int DrainCycles   = 4;     // settle time after the last expected result
  localparam int WatchdogLimit = 3000;  // quiet cycles before giving up
  localparam int PhaseSymbols  = 30;    // minimum symbol beats per timing setting in a phase
  localparam int PhaseResults  = 1;     // minimum frame results per timing setting in a phase

  // One decoded frame as it leaves the block
  typedef struct {
    logic [15:0] address;
    logic [15:0] command;
    logic        is_repeat;
  } frame_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i     = '0;
  logic [DurW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // mark_ticks, space_ticks, pad
  logic                s_axis_tlast  = 1'b0; // last_symbol
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // address, command
  logic                m_axis_tuser;         // is_repeat

  // Decoder state mirrored by the testbench
  dur_t        timing [8];
  dur_t        plan [8];
  int unsigned sym_count;
  logic        lead_seen;
  logic        rpt_seen;
  logic        sym_bad;
  logic [31:0] payload;
  logic [15:0] held_addr;
  logic [15:0] held_cmd;
  frame_res_t  frame_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;
  int symbols_sent   = 0;
  int results_due    = 0;
  int full_frames    = 0;
  int repeat_frames  = 0;
  int settings_used  = 1;

  nec_ir_frame_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame decoding as the block should do it
  // ---------------------------------------------------------------------------

  function automatic void clear_frame_state();
    sym_count = 0;
    lead_seen = 1'b0;
    rpt_seen  = 1'b0;
    sym_bad   = 1'b0;
    payload   = '0;
  endfunction

  function automatic void set_plan_defaults();
    plan[RegMargin]      = MarginRst;
    plan[RegLeadMark]    = LeadMarkRst;
    plan[RegLeadSpace]   = LeadSpaceRst;
    plan[RegRepeatMark]  = RepeatMarkRst;
    plan[RegRepeatSpace] = RepeatSpaceRst;
    plan[RegBitMark]     = BitMarkRst;
    plan[RegZeroSpace]   = ZeroSpaceRst;
    plan[RegOneSpace]    = OneSpaceRst;
  endfunction

  // Open window on both sides; widen to int so nothing wraps
  function automatic bit in_window(dur_t d, dur_t spec);
    int dv;
    int sv;
    int mv;
    dv = int'(d);
    sv = int'(spec);
    mv = int'(timing[RegMargin]);
    return (dv < sv + mv) && (dv + mv > sv);
  endfunction

  function automatic bit symbol_fits(dur_t mk, dur_t sp,
                                     logic [RegIdxW-1:0] mk_reg, logic [RegIdxW-1:0] sp_reg);
    return in_window(mk, timing[mk_reg]) && in_window(sp, timing[sp_reg]);
  endfunction

  // Advance the frame by one symbol; queue a result when a frame closes cleanly
  function automatic void decode_symbol(dur_t mk, dur_t sp, logic last);
    frame_res_t res;
    if (sym_count == 0) begin
      lead_seen = symbol_fits(mk, sp, RegLeadMark, RegLeadSpace);
      rpt_seen  = symbol_fits(mk, sp, RegRepeatMark, RegRepeatSpace);
    end else if (sym_count <= PayloadBits) begin
      // a symbol that fits both patterns counts as a one
      if (symbol_fits(mk, sp, RegBitMark, RegOneSpace)) begin
        payload[sym_count-1] = 1'b1;
      end else if (symbol_fits(mk, sp, RegBitMark, RegZeroSpace)) begin
        payload[sym_count-1] = 1'b0;
      end else begin
        sym_bad = 1'b1;
      end
    end
    // the stop symbol and anything after it go unchecked
    if (sym_count < CountMax) sym_count++;
    if (last) begin
      if (sym_count == FullSymbols && lead_seen && !sym_bad) begin
        held_addr = payload[HalfBits-1:0];
        held_cmd  = payload[PayloadBits-1:HalfBits];
        res = '{held_addr, held_cmd, 1'b0};
        frame_q.push_back(res);
        results_due++;
        full_frames++;
      end else if (sym_count == RepeatSymbols && rpt_seen) begin
        res = '{held_addr, held_cmd, 1'b1};
        frame_q.push_back(res);
        results_due++;
        repeat_frames++;
      end
      clear_frame_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Duration pickers
  // ---------------------------------------------------------------------------

  // A duration inside the window around spec, or spec itself if the window is empty
  function automatic dur_t near_value(dur_t spec);
    int lo;
    int hi;
    int m;
    m  = int'(timing[RegMargin]);
    lo = int'(spec) - m + 1;
    hi = int'(spec) + m - 1;
    if (lo < 0) lo = 0;
    if (hi > DurMax) hi = DurMax;
    if (m == 0 || lo > hi) return spec;
    return dur_t'($urandom_range(hi, lo));
  endfunction

  // A duration on or just inside one of the window edges
  function automatic dur_t edge_value(dur_t spec);
    int v;
    int m;
    m = int'(timing[RegMargin]);
    case ($urandom_range(3))
      0:       v = int'(spec) - m;
      1:       v = int'(spec) - m + 1;
      2:       v = int'(spec) + m - 1;
      default: v = int'(spec) + m;
    endcase
    if (v < 0) v = 0;
    if (v > DurMax) v = DurMax;
    return dur_t'(v);
  endfunction

  function automatic void pick_random_timing();
    if ($urandom_range(1)) begin
      foreach (plan[i]) plan[i] = dur_t'($urandom);
    end else begin
      set_plan_defaults();
    end
    // mostly narrow windows, now and then a margin drawn from the full range
    case ($urandom_range(3))
      0:       plan[RegMargin] = dur_t'($urandom_range(32, 1));
      1, 2:    plan[RegMargin] = dur_t'($urandom_range(1200, 1));
      default: plan[RegMargin] = dur_t'($urandom_range(DurMax, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with tvalid still high
  task automatic send_symbol(dur_t mk, dur_t sp, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({sp, mk});
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_symbol(mk, sp, last);
    symbols_sent++;
    @(negedge clk_i);
  endtask

  // Send symbols first..len-1 of a frame: leader, payload LSB first, then
  // random stop and trailing symbols. A bad position carries an edge-case space.
  task automatic send_nec_frame(logic [31:0] bits, int len, int bad_pos, logic close, int first);
    dur_t mk;
    dur_t sp;
    for (int i = first; i < len; i++) begin
      if (i == 0) begin
        mk = near_value(timing[RegLeadMark]);
        sp = near_value(timing[RegLeadSpace]);
      end else if (i <= PayloadBits && i == bad_pos) begin
        mk = $urandom_range(1) ? near_value(timing[RegBitMark]) : dur_t'($urandom);
        sp = edge_value($urandom_range(1) ? timing[RegOneSpace] : timing[RegZeroSpace]);
      end else if (i <= PayloadBits) begin
        mk = near_value(timing[RegBitMark]);
        sp = near_value(bits[i-1] ? timing[RegOneSpace] : timing[RegZeroSpace]);
      end else begin
        mk = dur_t'($urandom);
        sp = dur_t'($urandom);
      end
      send_symbol(mk, sp, close && (i == len - 1));
    end
  endtask

  task automatic send_repeat_frame(int len);
    send_symbol(near_value(timing[RegRepeatMark]), near_value(timing[RegRepeatSpace]), len == 1);
    for (int i = 1; i < len; i++) send_symbol(dur_t'($urandom), dur_t'($urandom), i == len - 1);
  endtask

  // Repeat-style frame whose first symbol is given
  task automatic probe_repeat(int mk, int sp);
    send_symbol(dur_t'(mk), dur_t'(sp), 1'b0);
    send_symbol(dur_t'($urandom), dur_t'($urandom), 1'b1);
  endtask

  // Junk symbols, half of them sitting on window edges; the last one closes the frame
  task automatic send_noise(int count);
    dur_t mk;
    dur_t sp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) begin
        mk = edge_value(timing[$urandom_range(RegOneSpace, RegLeadMark)]);
        sp = edge_value(timing[$urandom_range(RegOneSpace, RegLeadMark)]);
      end else begin
        mk = dur_t'($urandom);
        sp = dur_t'($urandom);
      end
      send_symbol(mk, sp, i == count - 1);
    end
  endtask

  // Drop tvalid, let every expected result out, then let the last symbol settle
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    wait (frame_q.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write all eight timing registers from plan while the block is idle
  task automatic load_timing();
    drain_pipeline();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[RegIdxW-1:0];
      cfg_wdata_i <= plan[i];
      timing[i]    = plan[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timings: repeat before any frame, payload and stop extremes, broken frames
  task automatic test_default_frames();
    send_repeat_frame(RepeatSymbols);                 // held values still zero
    send_nec_frame(32'h0000_FFFF, FullSymbols, 0, 1'b1, 0);
    send_repeat_frame(RepeatSymbols);
    send_nec_frame(32'hFFFF_0000, FullSymbols, 0, 1'b1, 0);
    send_nec_frame($urandom, FullSymbols, 1, 1'b1, 0);            // bad first bit
    send_nec_frame($urandom, FullSymbols, PayloadBits, 1'b1, 0);  // bad last bit
    send_repeat_frame(RepeatSymbols);                 // held values untouched
    // stop symbol at both extremes
    send_nec_frame($urandom, FullSymbols - 1, 0, 1'b0, 0);
    send_symbol('0, '0, 1'b1);
    send_nec_frame($urandom, FullSymbols - 1, 0, 1'b0, 0);
    send_symbol(dur_t'(DurMax), dur_t'(DurMax), 1'b1);
    // wrong lengths
    send_nec_frame($urandom, FullSymbols + 1, 0, 1'b1, 0);
    send_nec_frame($urandom, CountMax + 5, 0, 1'b1, 0);  // count saturates
    send_nec_frame($urandom, 1, 0, 1'b1, 0);
    send_nec_frame($urandom, RepeatSymbols, 0, 1'b1, 0); // leader is no repeat code
    send_repeat_frame(1);
    send_repeat_frame(RepeatSymbols + 1);
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 0);
  endtask

  // Reset timings: durations on and just inside the repeat and leader window edges, then noise
  task automatic test_window_edges();
    int m;
    int rm;
    int rs;
    int lm;
    int ls;
    m  = int'(timing[RegMargin]);
    rm = int'(timing[RegRepeatMark]);
    rs = int'(timing[RegRepeatSpace]);
    lm = int'(timing[RegLeadMark]);
    ls = int'(timing[RegLeadSpace]);
    probe_repeat(rm + m - 1, rs - m + 1);
    probe_repeat(rm - m + 1, rs + m - 1);
    probe_repeat(rm + m, rs);
    probe_repeat(rm - m, rs);
    probe_repeat(rm, rs + m);
    probe_repeat(rm, rs - m);
    probe_repeat(0, 0);
    probe_repeat(DurMax, DurMax);
    // leader on its edges, rest of the frame clean
    send_symbol(dur_t'(lm - m + 1), dur_t'(ls + m - 1), 1'b0);
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 1);
    send_symbol(dur_t'(lm + m), dur_t'(ls), 1'b0);
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 1);
    send_noise(12);
  endtask

  // Extreme register values, then back to the reset timings
  task automatic test_extreme_timing();
    // zero margin: every window is empty, so nothing decodes
    set_plan_defaults();
    plan[RegMargin] = '0;
    load_timing();
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 0);
    send_repeat_frame(RepeatSymbols);

    // widest margin around zero specs: everything below the top value fits
    plan = '{default: '0};
    plan[RegMargin] = dur_t'(DurMax);
    load_timing();
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 0);
    send_repeat_frame(RepeatSymbols);
    send_symbol('0, '0, 1'b0);
    send_symbol(dur_t'(DurMax), '0, 1'b1);

    // widest margin around top specs: everything above zero fits
    plan = '{default: dur_t'(DurMax)};
    load_timing();
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 0);
    send_symbol('0, dur_t'(DurMax), 1'b0);
    send_symbol('0, '0, 1'b1);
    send_repeat_frame(RepeatSymbols);

    // zero and one share a space: every bit fits both and reads as one
    set_plan_defaults();
    plan[RegOneSpace] = plan[RegZeroSpace];
    load_timing();
    send_nec_frame(32'h0000_0000, FullSymbols, 0, 1'b1, 0);

    set_plan_defaults();
    load_timing();
    send_nec_frame($urandom, FullSymbols, 0, 1'b1, 0);
  endtask

  // Mostly well-formed frames with random content; the rest broken or junk
  task automatic run_random_phase(int idle_pct, int stall_pct);
    int start_syms;
    int start_res;
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      pick_random_timing();
      load_timing();
      start_syms = symbols_sent;
      start_res  = results_due;
      while (symbols_sent - start_syms < PhaseSymbols || results_due - start_res < PhaseResults) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_nec_frame($urandom, FullSymbols, 0, 1'b1, 0);
        end else if (pick < 72) begin
          send_repeat_frame(RepeatSymbols);
        end else if (pick < 78) begin
          send_nec_frame($urandom, FullSymbols, $urandom_range(PayloadBits, 1), 1'b1, 0);
        end else if (pick < 84) begin
          send_nec_frame($urandom, $urandom_range(FullSymbols + 3, 1), 0, 1'b1, 0);
        end else if (pick < 88) begin
          send_repeat_frame($urandom_range(RepeatSymbols + 2, 1));
        end else if (pick < 90) begin
          send_nec_frame($urandom, $urandom_range(CountMax + 6, CountMax - 2), 0, 1'b1, 0);
        end else begin
          send_noise($urandom_range(6, 1));
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(61, 0);
    run_random_phase(0, 61);
    run_random_phase(24, 24);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result stream at the rate the current phase asks for
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every result beat with the oldest decoded frame
  always @(posedge clk_i) begin
    frame_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: address %h command %h repeat %b",
                 $time, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
        fail_count++;
      end else begin
        want = frame_q.pop_front();
        if (m_axis_tdata[15:0] !== want.address) begin
          $display("%0t: address mismatch: expected %h, got %h",
                   $time, want.address, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== want.command) begin
          $display("%0t: command mismatch: expected %h, got %h",
                   $time, want.command, m_axis_tdata[31:16]);
          fail_count++;
        end
        if (m_axis_tuser !== want.is_repeat) begin
          $display("%0t: is_repeat mismatch: expected %b, got %b",
                   $time, want.is_repeat, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Give up when neither stream has moved for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, frame_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    set_plan_defaults();
    timing = plan;
    clear_frame_state();
    held_addr = '0;
    held_cmd  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_frames();
    test_window_edges();
    test_extreme_timing();
    test_random_traffic();

    // let the tail drain, then a few spare cycles for stray beats
    drain_pipeline();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d symbol beats over %0d timing settings and four idling phases;",
             symbols_sent, settings_used);
    $display("checked %0d full frames and %0d repeat codes, %0d mismatches.",
             full_frames, repeat_frames, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/necir_pkg.sv
hw/rtl/necir_match.sv
hw/rtl/necir_frame.sv
hw/rtl/nec_ir_frame_decoder.sv
hw/rtl/necir_checker.sv
tb/nec_ir_frame_decoder_test.sv
